>>> sv/ipv4_range_table_lookup_defines.svh
// ----------------------------------------------------------------------------
// IPv4 range table lookup: assertion macros
// Shared property shorthands, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_RANGE_TABLE_LOOKUP_DEFINES_SVH
`define IPV4_RANGE_TABLE_LOOKUP_DEFINES_SVH

// Same-cycle implication.
`define IPRTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iprtl: same-cycle check failed");

// Next-cycle implication.
`define IPRTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iprtl: next-cycle check failed");

`endif

>>> sv/iprtl_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 range table lookup: package
// Field widths, request codes and the stored range entry type.
// ----------------------------------------------------------------------------
package iprtl_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int ADDR_W          = 32;
    localparam int SLOT_W          = 12;
    localparam int CFG_W           = 13;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
    } t_range_entry;

endpackage

>>> sv/iprtl_ram.sv
// ----------------------------------------------------------------------------
// IPv4 range table lookup: range table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iprtl_ram
    import iprtl_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int IDX_W = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_range_entry     i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_range_entry     o_rdata
);

    t_range_entry r_mem [DEPTH];
    t_range_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ipv4_range_table_lookup.sv
// ----------------------------------------------------------------------------
// IPv4 range table lookup
// Table of inclusive address ranges sorted by start; a query runs a
// lower-bound binary search and checks the candidate range.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start / busy           i_req_type, i_entry_index, i_range_start,
//                                   i_range_end, i_query_addr
//  result    o_result_valid strobe  o_hit, o_match_index
//  config    i_cfg_we               i_cfg_wdata (entry_count)
//
//  A load's word appears on the cycle after acceptance.
//  A query on an empty table goes from S_BASE straight back to idle; else it
//  runs s <= ceil(log2(n + 1)) search steps for n = entry_count capped at
//  MAX_ENTRIES, one table read each, then S_BASE and the candidate checks;
//  its word appears on the first cycle with busy low again.
//  Reset is synchronous and the table is not cleared; words cannot be stalled.
// ----------------------------------------------------------------------------
`include "ipv4_range_table_lookup_defines.svh"

module ipv4_range_table_lookup
    import iprtl_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [ADDR_W-1:0] i_range_start,
    input  logic [ADDR_W-1:0] i_range_end,
    input  logic [ADDR_W-1:0] i_query_addr,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_result_valid,
    output logic              o_hit,
    output logic [SLOT_W-1:0] o_match_index
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_BASE = 3'd2;
    localparam logic [2:0] S_BCHK = 3'd3;
    localparam logic [2:0] S_PCHK = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_entry_count;
    logic [CNT_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_out_valid, n_out_valid;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_idx, n_idx;

    logic              w_accept;
    logic              w_load_we;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W-1:0]  w_half;
    logic [CNT_W-1:0]  w_step_base;
    logic [CNT_W-1:0]  w_step_left;
    logic [CNT_W-1:0]  w_step_mid;
    logic [CNT_W-1:0]  w_prev;
    logic [CNT_W-1:0]  w_raddr;
    logic              w_lt;
    logic              w_eq;
    logic              w_in_end;
    t_range_entry      w_wdata;
    t_range_entry      w_rdata;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Loads aimed beyond the table are dropped but still answered.
    assign w_load_we = w_accept && (i_req_type == REQ_LOAD)
                       && (32'(i_entry_index) < 32'(MAX_ENTRIES));

    assign w_wdata.range_start = i_range_start;
    assign w_wdata.range_end   = i_range_end;

    assign w_count = (32'(r_entry_count) > 32'(MAX_ENTRIES)) ?
                     CNT_W'(MAX_ENTRIES) : CNT_W'(r_entry_count);

    // Shared compare unit on the word just read from the table.
    assign w_lt     = w_rdata.range_start <  r_addr;
    assign w_eq     = w_rdata.range_start == r_addr;
    assign w_in_end = r_addr <= w_rdata.range_end;

    assign w_half      = r_left >> 1;
    assign w_step_base = w_lt ? (r_base + w_half + CNT_W'(1)) : r_base;
    assign w_step_left = w_lt ? (r_left - w_half - CNT_W'(1)) : w_half;
    assign w_step_mid  = w_step_base + (w_step_left >> 1);
    assign w_prev      = r_base - CNT_W'(1);

    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = w_count >> 1;
            S_STEP:  w_raddr = w_step_mid;
            S_BASE:  w_raddr = (r_base != r_n) ? r_base : w_prev;
            S_BCHK:  w_raddr = w_prev;
            default: w_raddr = r_base;
        endcase
    end

    iprtl_ram #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (i_entry_index[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_left      = r_left;
        n_n         = r_n;
        n_addr      = r_addr;
        n_out_valid = 1'b0;
        n_hit       = r_hit;
        n_idx       = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        n_out_valid = 1'b1;
                        n_hit       = 1'b0;
                        n_idx       = '0;
                    end else begin
                        n_addr  = i_query_addr;
                        n_n     = w_count;
                        n_base  = '0;
                        n_left  = w_count;
                        n_state = (w_count != '0) ? S_STEP : S_BASE;
                    end
                end
            end
            S_STEP: begin
                n_base = w_step_base;
                n_left = w_step_left;
                if (w_step_left == '0) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (r_base != r_n) begin
                    n_state = S_BCHK;
                end else if (r_base == '0) begin
                    n_out_valid = 1'b1;
                    n_hit       = 1'b0;
                    n_idx       = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_BCHK: begin
                if (w_eq) begin
                    n_out_valid = 1'b1;
                    n_hit       = w_in_end;
                    n_idx       = w_in_end ? r_base[IDX_W-1:0] : '0;
                    n_state     = S_IDLE;
                end else if (r_base == '0) begin
                    n_out_valid = 1'b1;
                    n_hit       = 1'b0;
                    n_idx       = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                n_out_valid = 1'b1;
                n_hit       = (w_lt || w_eq) && w_in_end;
                n_idx       = ((w_lt || w_eq) && w_in_end) ? w_prev[IDX_W-1:0] : '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_left <= n_left;
        r_n    <= n_n;
        r_addr <= n_addr;
        r_hit  <= n_hit;
        r_idx  <= n_idx;
    end

    assign o_result_valid = r_out_valid;
    assign o_hit          = r_hit;
    assign o_match_index  = SLOT_W'(r_idx);

    `IPRTL_ASSERT_NEXT(a_query_goes_busy, w_accept && (i_req_type == REQ_QUERY), busy)
    `IPRTL_ASSERT_NEXT(a_load_answers_miss, w_accept && (i_req_type == REQ_LOAD), o_result_valid && !o_hit)
    `IPRTL_ASSERT_NOW(a_miss_has_zero_index, o_result_valid && !o_hit, o_match_index == '0)
    `IPRTL_ASSERT_NOW(a_step_has_span, r_state == S_STEP, r_left != '0)

endmodule

>>> tb/sv/range_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range table lookup: result checker
// Watches the request, config and result channels of the block, keeps its own
// copy of the range table and the entry count, predicts each result word and
// compares it field by field against what the block delivers.
// ----------------------------------------------------------------------------
module range_lookup_checker
    import iprtl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_req_type,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [ADDR_W-1:0] i_range_start,
    input  logic [ADDR_W-1:0] i_range_end,
    input  logic [ADDR_W-1:0] i_query_addr,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_result_valid,
    input  logic              i_hit,
    input  logic [SLOT_W-1:0] i_match_index,
    output int                o_fail_count,
    output int                o_pending_words
);

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] match_index;
    } t_lookup_word;

    logic [ADDR_W-1:0] start_mem [MAX_ENTRIES_DEF];
    logic [ADDR_W-1:0] end_mem   [MAX_ENTRIES_DEF];
    logic [CFG_W-1:0]  entry_count_q;
    t_lookup_word      expected_q [$];

    // Lower-bound search for the first slot whose start is not below the
    // address; an exact start match wins, otherwise the slot before it.
    function automatic t_lookup_word predict_lookup(logic [ADDR_W-1:0] addr);
        int unsigned  n;
        int unsigned  lo;
        int unsigned  left;
        int unsigned  half;
        int unsigned  mid;
        int unsigned  cand;
        t_lookup_word w;
        w = '0;
        n = (entry_count_q > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : entry_count_q;
        lo = 0;
        left = n;
        while (left > 0) begin
            half = left >> 1;
            mid = lo + half;
            if (start_mem[mid] < addr) begin
                lo = mid + 1;
                left = left - (half + 1);
            end else begin
                left = half;
            end
        end
        if (lo != n && start_mem[lo] == addr) begin
            cand = lo;
        end else if (lo == 0) begin
            return w;
        end else begin
            cand = lo - 1;
        end
        if (start_mem[cand] <= addr && addr <= end_mem[cand]) begin
            w.hit = 1'b1;
            w.match_index = cand[SLOT_W-1:0];
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_word expected_word;
        if (!i_rst_n) begin
            entry_count_q = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                entry_count_q = i_cfg_wdata;
            end
            // Push before pop so that a word delivered at its own acceptance
            // edge still finds its expectation.
            if (i_start && !i_busy) begin
                if (i_req_type == REQ_LOAD) begin
                    start_mem[i_entry_index] = i_range_start;
                    end_mem[i_entry_index] = i_range_end;
                    expected_q.push_back('0);
                end else begin
                    expected_q.push_back(predict_lookup(i_query_addr));
                end
            end
            if (i_result_valid) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: hit %0b match_index %0d",
                           i_hit, i_match_index);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    expected_word = expected_q.pop_front();
                    if (i_hit !== expected_word.hit) begin
                        $error("hit: expected %0b, actual %0b", expected_word.hit, i_hit);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_match_index !== expected_word.match_index) begin
                        $error("match_index: expected %0d, actual %0d",
                               expected_word.match_index, i_match_index);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending_words <= expected_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range table lookup: testbench top
// Loads sorted, adjacent, duplicate and unsorted range tables, sweeps the
// entry count from empty to oversized and queries addresses at and around
// range boundaries, with random sender gaps; a checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import iprtl_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 620;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic              i_req_type    = REQ_LOAD;
    logic [SLOT_W-1:0] i_entry_index = '0;
    logic [ADDR_W-1:0] i_range_start = '0;
    logic [ADDR_W-1:0] i_range_end   = '0;
    logic [ADDR_W-1:0] i_query_addr  = '0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              o_result_valid;
    logic              o_hit;
    logic [SLOT_W-1:0] o_match_index;

    int fail_count;
    int pending_words;
    int cycle_count = 0;

    bit          idle_on = 1'b0;
    int unsigned items_sent = 0;
    int unsigned prefix_written = 0;
    int unsigned entry_count_set = 0;

    // Table contents as loaded, used only to aim query addresses.
    logic [ADDR_W-1:0] tbl_start [MAX_ENTRIES_DEF];
    logic [ADDR_W-1:0] tbl_end   [MAX_ENTRIES_DEF];

    ipv4_range_table_lookup dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_entry_index  (i_entry_index),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .i_query_addr   (i_query_addr),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_match_index  (o_match_index)
    );

    range_lookup_checker u_lookup_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_query_addr    (i_query_addr),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_result_valid  (o_result_valid),
        .i_hit           (o_hit),
        .i_match_index   (o_match_index),
        .o_fail_count    (fail_count),
        .o_pending_words (pending_words)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** ipv4_range_table_lookup: FAILED **");
            $finish;
        end
    end

    // Start stays high from one word to the next; it is lowered only for a
    // gap, before a config write and at the end.
    task automatic send_item(logic kind, logic [SLOT_W-1:0] idx, logic [ADDR_W-1:0] rs,
                             logic [ADDR_W-1:0] re, logic [ADDR_W-1:0] qa);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= kind;
        i_entry_index <= idx;
        i_range_start <= rs;
        i_range_end   <= re;
        i_query_addr  <= qa;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic send_load(logic [SLOT_W-1:0] idx, logic [ADDR_W-1:0] rs,
                             logic [ADDR_W-1:0] re);
        tbl_start[idx] = rs;
        tbl_end[idx] = re;
        send_item(REQ_LOAD, idx, rs, re, $urandom);
    endtask

    task automatic send_query(logic [ADDR_W-1:0] qa);
        send_item(REQ_QUERY, SLOT_W'($urandom_range(0, MAX_ENTRIES_DEF - 1)),
                  $urandom, $urandom, qa);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_entry_count(int unsigned value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        entry_count_set = value;
    endtask

    // Fills slots 0..n-1. Most tables are sorted with gaps, some are packed
    // back to back, a few carry repeated starts, empty ranges or no order.
    task automatic fill_table(int unsigned n, bit sorted_only);
        longint unsigned seg;
        longint unsigned base;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
        logic [ADDR_W-1:0] prev_s;
        int unsigned mode;
        seg = 64'h1_0000_0000 / n;
        mode = $urandom_range(sorted_only ? 3 : 0, 19);
        prev_s = '0;
        for (int unsigned i = 0; i < n; i++) begin
            base = i * seg;
            if (mode < 3) begin
                s = $urandom;
                e = s + $urandom_range(0, 1 << 20);
            end else if (mode < 8) begin
                s = base[ADDR_W-1:0];
                e = (i == n - 1) ? 32'hFFFF_FFFF : 32'(base + seg - 1);
            end else begin
                s = 32'(base + $urandom_range(0, 32'(seg / 4)));
                if (i > 0 && $urandom_range(0, 7) == 0) s = prev_s;
                e = s + $urandom_range(0, 32'(seg / 2));
                if ($urandom_range(0, 15) == 0) e = s - 1;
            end
            prev_s = s;
            send_load(i[SLOT_W-1:0], s, e);
        end
        if (n > prefix_written) prefix_written = n;
    endtask

    // Loads only the slots that a full-table search visits when every start
    // it meets lies below the address; starts rise along that path.
    task automatic load_last_path();
        int unsigned lo;
        int unsigned left;
        int unsigned half;
        logic [ADDR_W-1:0] s;
        lo = 0;
        left = MAX_ENTRIES_DEF;
        while (left > 0) begin
            half = left >> 1;
            s = 32'((lo + half) << 16);
            send_load(SLOT_W'(lo + half), s, s + 32'($urandom_range(0, 32'h0001_FFFF)));
            lo = lo + half + 1;
            left = left - (half + 1);
        end
    endtask

    // Addresses above the start of the second to last slot keep the search
    // on the loaded path.
    function automatic logic [ADDR_W-1:0] pick_last_path_addr();
        return tbl_start[MAX_ENTRIES_DEF - 2] + 32'($urandom_range(1, 32'h0003_0000));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_query_addr();
        int unsigned n;
        int unsigned k;
        longint unsigned span;
        n = (entry_count_set > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : entry_count_set;
        if (n == 0) return $urandom;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1: return tbl_start[k];
            2:    return tbl_end[k];
            3:    return tbl_start[k] - 1;
            4:    return tbl_end[k] + 1;
            5, 6: begin
                if (tbl_end[k] < tbl_start[k]) return tbl_start[k];
                span = longint'(tbl_end[k]) - longint'(tbl_start[k]) + 1;
                return 32'(longint'(tbl_start[k]) + {32'b0, $urandom} % span);
            end
            7:    return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned n;
        int unsigned random_target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table after reset, then with the count written as zero.
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);
        set_entry_count(0);
        send_load(12'd0, 32'h0000_0010, 32'h0000_001F);
        send_load(12'd1, 32'h0000_0100, 32'h0000_01FF);
        send_load(12'd2, 32'h8000_0000, 32'h8000_0000);
        send_load(12'd3, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_load(12'd4095, 32'h0, 32'hFFFF_FFFF);
        send_load(12'd4095, 32'hFFFF_FFFF, 32'h0);
        send_query(32'h0000_0010);
        set_entry_count(4);
        prefix_written = 4;
        send_query(32'h0);            // below every start
        send_query(32'h0000_0010);
        send_query(32'h0000_001F);
        send_query(32'h0000_0020);
        send_query(32'h0000_0100);
        send_query(32'h0000_017F);
        send_query(32'h8000_0000);
        send_query(32'h8000_0001);
        send_query(32'h7FFF_FFFF);
        send_query(32'hFFFF_FF00);
        send_query(32'hFFFF_FFFF);
        // Break the order: slot 1 now starts above slot 2.
        send_load(12'd1, 32'h9000_0000, 32'h9000_000F);
        send_query(32'h9000_0005);
        send_query(32'h0000_0100);

        random_target = items_sent + RANDOM_ITEMS;
        while (items_sent < random_target) begin
            idle_on = ($urandom_range(0, 3) != 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
            fill_table(n, 1'b0);
            if ($urandom_range(0, 5) == 0) set_entry_count($urandom_range(0, prefix_written));
            else set_entry_count(n);
            repeat ($urandom_range(20, 80)) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_load(SLOT_W'($urandom_range(0, MAX_ENTRIES_DEF - 1)),
                              $urandom, $urandom);
                end else begin
                    send_query(pick_query_addr());
                end
            end
        end

        // Full-size count, then a count beyond the table size, on a search
        // path that ends at the last slot; no gaps from here on.
        idle_on = 1'b0;
        load_last_path();
        set_entry_count(MAX_ENTRIES_DEF);
        repeat (30) send_query(pick_last_path_addr());
        set_entry_count((1 << CFG_W) - 1);
        repeat (30) send_query(pick_last_path_addr());

        wait_idle();
        repeat (32) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** ipv4_range_table_lookup: PASSED **");
        end else begin
            $display("** ipv4_range_table_lookup: FAILED **");
        end
        $finish;
    end

endmodule
